[src/rfdo_pkg.sv]
`default_nettype none

package rfdo_pkg;

	// Field widths of the stream payloads.
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned CNT_W    = 5;
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned STAT_W   = 2;
	localparam int unsigned S_TDATA_W = 40;
	localparam int unsigned M_TDATA_W = 40;

	// Operation carried in s_tuser.
	typedef enum logic [CMD_W-1:0] {
		OP_PUT   = 2'd0,
		OP_GET   = 2'd1,
		OP_PEEK  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	// Result status carried in m_tuser.
	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_NONE  = 2'd2,
		ST_SPARE = 2'd3
	} res_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;     // request accepted on the input this cycle
		logic load;     // move the registered read word into the output slot
		logic next_rd;  // start the next read of a peek
	} dp_ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic slot_free;   // output register is empty or being emptied
		logic needs_read;  // the request on the input goes through the memory
		logic last_rd;     // the pending read is the final one of its request
	} dp_stat_t;

endpackage

`default_nettype wire

[src/rfdo_ctrl.sv]
`default_nettype none

module rfdo_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	output rfdo_pkg::dp_ctrl_t      ctrl,
	input  wire rfdo_pkg::dp_stat_t stat
);

	typedef enum logic [0:0] {
		S_IDLE,
		S_READ
	} state_t;

	state_t state_q;

	assign s_tready = (state_q == S_IDLE) && stat.slot_free;

	always_comb begin
		ctrl.take    = s_tvalid && s_tready;
		ctrl.load    = (state_q == S_READ) && stat.slot_free;
		ctrl.next_rd = (state_q == S_READ) && stat.slot_free && !stat.last_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (ctrl.take && stat.needs_read) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (ctrl.load && stat.last_rd) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[src/rfdo_dp.sv]
`default_nettype none

module rfdo_dp #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire rfdo_pkg::dp_ctrl_t                  ctrl,
	output rfdo_pkg::dp_stat_t                       stat,
	input  wire logic [rfdo_pkg::S_TDATA_W-1:0]      s_tdata,
	input  wire logic [rfdo_pkg::CMD_W-1:0]          s_tuser,
	input  wire logic                                cfg_wr_en,
	input  wire logic                                cfg_wr_data,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [rfdo_pkg::M_TDATA_W-1:0]           m_tdata,
	output logic [rfdo_pkg::STAT_W-1:0]              m_tuser,
	output logic                                     m_tlast
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned NW = (CW > rfdo_pkg::CNT_W) ? CW : rfdo_pkg::CNT_W;
	localparam int unsigned WW = rfdo_pkg::WORD_W;
	localparam int unsigned FW = rfdo_pkg::CNT_W;

	function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
		adv = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	// Storage and pointers.
	logic [WW-1:0] mem [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q, pos_q;
	logic [CW-1:0] cnt_q, rem_q;
	logic          full_q;
	logic          mode_q;
	logic [WW-1:0] rd_data_q;

	// Output slot.
	logic                    out_valid_q;
	rfdo_pkg::res_t          out_status_q;
	logic [WW-1:0]           out_data_q;
	logic                    out_last_q;
	logic [FW-1:0]           out_cnt_q;
	logic                    out_full_q;
	logic                    out_empty_q;

	// Request decode and next state.
	rfdo_pkg::op_t  op;
	logic [WW-1:0]  data_in;
	logic [FW-1:0]  want;
	logic           is_empty;
	logic           refuse;
	logic [NW-1:0]  peek_n_w;
	logic [CW-1:0]  peek_n;
	logic [PW-1:0]  wptr_d, rptr_d;
	logic [CW-1:0]  cnt_d;
	logic           full_d;
	logic           put_ok;
	logic           needs_read;
	rfdo_pkg::res_t dir_status;
	logic           rd_en;
	logic [PW-1:0]  rd_addr;
	logic           slot_free;

	assign op       = rfdo_pkg::op_t'(s_tuser);
	assign data_in  = s_tdata[WW-1:0];
	assign want     = s_tdata[WW+FW-1:WW];
	assign is_empty = (cnt_q == '0) && !full_q;
	assign refuse   = full_q && !mode_q;
	assign peek_n_w = (NW'(want) < NW'(cnt_q)) ? NW'(want) : NW'(cnt_q);
	assign peek_n   = CW'(peek_n_w);

	always_comb begin
		wptr_d     = wptr_q;
		rptr_d     = rptr_q;
		cnt_d      = cnt_q;
		full_d     = full_q;
		put_ok     = 1'b0;
		needs_read = 1'b0;
		dir_status = rfdo_pkg::ST_OK;
		unique case (op)
			rfdo_pkg::OP_PUT: begin
				if (refuse) begin
					dir_status = rfdo_pkg::ST_FULL;
				end else begin
					put_ok = 1'b1;
					wptr_d = adv(wptr_q);
					if (full_q) begin
						rptr_d = adv(rptr_q);
					end else begin
						cnt_d  = cnt_q + CW'(1);
						full_d = (cnt_q == CW'(DEPTH - 1));
					end
				end
			end
			rfdo_pkg::OP_GET: begin
				if (is_empty) begin
					dir_status = rfdo_pkg::ST_NONE;
				end else begin
					needs_read = 1'b1;
					rptr_d     = adv(rptr_q);
					cnt_d      = cnt_q - CW'(1);
					full_d     = 1'b0;
				end
			end
			rfdo_pkg::OP_PEEK: begin
				if (is_empty || (want == '0)) begin
					dir_status = rfdo_pkg::ST_NONE;
				end else begin
					needs_read = 1'b1;
				end
			end
			rfdo_pkg::OP_CLEAR: begin
				wptr_d = '0;
				rptr_d = '0;
				cnt_d  = '0;
				full_d = 1'b0;
			end
			default: begin
				dir_status = rfdo_pkg::ST_OK;
			end
		endcase
	end

	assign slot_free = !out_valid_q || m_tready;

	always_comb begin
		stat.slot_free  = slot_free;
		stat.needs_read = needs_read;
		stat.last_rd    = (rem_q == '0);
	end

	// A peek walks forward from the read pointer; the first read uses the
	// read pointer itself, later ones the saved position.
	assign rd_en   = (ctrl.take && needs_read) || ctrl.next_rd;
	assign rd_addr = ctrl.next_rd ? pos_q : rptr_q;

	always_ff @(posedge clk) begin
		if (ctrl.take && put_ok) begin
			mem[wptr_q] <= data_in;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q      <= '0;
			rptr_q      <= '0;
			cnt_q       <= '0;
			full_q      <= 1'b0;
			mode_q      <= 1'b0;
			pos_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
			if (ctrl.take) begin
				wptr_q <= wptr_d;
				rptr_q <= rptr_d;
				cnt_q  <= cnt_d;
				full_q <= full_d;
				if (needs_read) begin
					pos_q <= adv(rptr_q);
					rem_q <= (op == rfdo_pkg::OP_PEEK) ? peek_n - CW'(1) : '0;
				end
			end else if (ctrl.next_rd) begin
				pos_q <= adv(pos_q);
				rem_q <= rem_q - CW'(1);
			end
			if ((ctrl.take && !needs_read) || ctrl.load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take && !needs_read) begin
			out_status_q <= dir_status;
			out_data_q   <= '0;
			out_last_q   <= 1'b1;
			out_cnt_q    <= FW'(cnt_d);
			out_full_q   <= full_d;
			out_empty_q  <= (cnt_d == '0) && !full_d;
		end else if (ctrl.load) begin
			out_status_q <= rfdo_pkg::ST_OK;
			out_data_q   <= rd_data_q;
			out_last_q   <= (rem_q == '0);
			out_cnt_q    <= FW'(cnt_q);
			out_full_q   <= full_q;
			out_empty_q  <= is_empty;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {
		(rfdo_pkg::M_TDATA_W - WW - FW - 2)'(0),
		out_empty_q, out_full_q, out_cnt_q, out_data_q
	};

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("fill count exceeds the depth");

	a_full_agrees: assert property (@(posedge clk) disable iff (!arst_n)
		full_q == (cnt_q == CW'(DEPTH)))
		else $error("full mark disagrees with the fill count");

	a_peek_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.next_rd |-> (rem_q != '0))
		else $error("peek read issued beyond its final entry");

endmodule

`default_nettype wire

[src/ring_fifo_drop_or_overwrite.sv]
`default_nettype none

// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tuser: cmd; s_tdata: data_in, peek_count
// m_*      out  m_tvalid/m_tready  m_tuser: status; m_tlast: last;
//                                  m_tdata: data_out, fill_count, full, empty
// cfg_*    in   cfg_wr_en          cfg_wr_data: overwrite_mode
//
// A put, a clear, a refused put or an empty get or peek is answered in the cycle after acceptance.
// A get is answered once its word has passed the registered memory read port and the output
// register; a peek of n entries makes one read per result. A new request is taken once the
// controller is idle and the output register is empty or being emptied. Reset clears the
// pointers, the count and the policy register; the word store is not cleared and needs no pass.
// Backpressure on the output simply holds the result and pauses the peek walk.

module ring_fifo_drop_or_overwrite #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Requests in.
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// Bits 31:0 data_in, 36:32 peek_count, 39:37 zero.
	input  wire logic [rfdo_pkg::S_TDATA_W-1:0] s_tdata,
	// Bits 1:0 cmd.
	input  wire logic [rfdo_pkg::CMD_W-1:0]     s_tuser,
	// Results out.
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// Bits 31:0 data_out, 36:32 fill_count, 37 full_flag, 38 empty_flag, 39 zero.
	output logic [rfdo_pkg::M_TDATA_W-1:0]      m_tdata,
	// Bits 1:0 status.
	output logic [rfdo_pkg::STAT_W-1:0]         m_tuser,
	output logic                                m_tlast,
	// Policy register: 1 lets a put overwrite the oldest entry when full.
	input  wire logic                           cfg_wr_en,
	input  wire logic                           cfg_wr_data
);

	// The controller sequences each request; the datapath holds the store,
	// the pointers and the output register.
	rfdo_pkg::dp_ctrl_t ctrl;
	rfdo_pkg::dp_stat_t stat;

	rfdo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.ctrl     (ctrl),
		.stat     (stat)
	);

	rfdo_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.stat        (stat),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps

// Bench for the ring FIFO with its drop-or-overwrite put policy.
//
// Requests are put on the slave stream from a queue of pending requests. The
// queue is filled by the sequencing initial block below. The driver works on
// the falling clock edge. The monitor samples both streams on the rising edge.
// For every request that it sees accepted, the monitor runs a shadow copy of
// the FIFO. That copy holds its own words, pointers, count, full mark and
// overwrite policy, and it queues the results the block must return. Each
// result that leaves the master stream is checked field by field against the
// oldest awaited one.
//
// The policy register is written only while the block is idle: no pending
// request, no request offered, and nothing awaited. Every request gives at
// least one result, so an empty store of awaited results means the block has
// finished its work.

module tb;

	localparam int unsigned FIFO_DEPTH = 16;
	localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);

	typedef struct {
		rfdo_pkg::op_t                    op;
		logic [rfdo_pkg::WORD_W-1:0]      word;
		logic [rfdo_pkg::CNT_W-1:0]       peek_max;
	} fifo_req_t;

	typedef struct {
		rfdo_pkg::res_t                   status;
		logic [rfdo_pkg::WORD_W-1:0]      word;
		logic                             last;
		logic [rfdo_pkg::CNT_W-1:0]       fill;
		logic                             full;
		logic                             empty;
	} fifo_answer_t;

	logic                               clk         = 1'b0;
	logic                               arst_n      = 1'b0;
	logic                               s_tvalid    = 1'b0;
	logic                               s_tready;
	// Bits 31:0 data_in, 36:32 peek_count, 39:37 zero.
	logic [rfdo_pkg::S_TDATA_W-1:0]     s_tdata     = '0;
	// Bits 1:0 cmd.
	logic [rfdo_pkg::CMD_W-1:0]         s_tuser     = '0;
	logic                               m_tvalid;
	logic                               m_tready    = 1'b0;
	// Bits 31:0 data_out, 36:32 fill_count, 37 full_flag, 38 empty_flag, 39 zero.
	logic [rfdo_pkg::M_TDATA_W-1:0]     m_tdata;
	// Bits 1:0 status.
	logic [rfdo_pkg::STAT_W-1:0]        m_tuser;
	logic                               m_tlast;
	logic                               cfg_wr_en   = 1'b0;
	logic                               cfg_wr_data = 1'b0;

	// Requests waiting to be offered, and results the block still owes.
	fifo_req_t                          pending_reqs[$];
	fifo_answer_t                       awaited_answers[$];

	// Shadow copy of the FIFO state and of the policy register.
	logic [rfdo_pkg::WORD_W-1:0]        shadow_words[FIFO_DEPTH];
	logic [PTR_W-1:0]                   shadow_wr        = '0;
	logic [PTR_W-1:0]                   shadow_rd        = '0;
	logic [rfdo_pkg::CNT_W-1:0]         shadow_count     = '0;
	logic                               shadow_full      = 1'b0;
	logic                               shadow_overwrite = 1'b0;

	// Set by the monitor when a request is accepted, and cleared by the driver.
	logic                               req_taken        = 1'b0;
	// Chance, in percent, that the sender idles or the receiver stalls in a cycle.
	int unsigned                        send_idle_pct    = 0;
	int unsigned                        recv_stall_pct   = 0;
	int unsigned                        mismatch_count   = 0;

	ring_fifo_drop_or_overwrite #(
		.DEPTH(FIFO_DEPTH)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #10 clk = ~clk;

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string what,
			input logic [rfdo_pkg::WORD_W-1:0] got,
			input logic [rfdo_pkg::WORD_W-1:0] want);
		mismatch_count++;
		$display("tb: %s mismatch at %0t ns: got %h, want %h", what, $time, got, want);
	endtask

	function automatic logic fifo_is_empty();
		return shadow_count == '0 && !shadow_full;
	endfunction

	// Queues one result. The fill count and flags are taken from the shadow state
	// as it stands after the operation.
	task automatic await_answer(input rfdo_pkg::res_t status,
			input logic [rfdo_pkg::WORD_W-1:0] word, input logic last);
		fifo_answer_t a;
		a.status = status;
		a.word   = word;
		a.last   = last;
		a.fill   = shadow_count;
		a.full   = shadow_full;
		a.empty  = fifo_is_empty();
		awaited_answers.push_back(a);
	endtask

	// Applies one accepted request to the shadow FIFO and queues its results.
	task automatic predict_fifo_answers(input fifo_req_t r);
		logic [PTR_W-1:0]            pos;
		logic [rfdo_pkg::WORD_W-1:0] word;
		int unsigned                 shown;
		case (r.op)
			rfdo_pkg::OP_PUT: begin
				if (shadow_full && !shadow_overwrite) begin
					// The FIFO is full and the policy drops the new word.
					await_answer(rfdo_pkg::ST_FULL, '0, 1'b1);
				end else begin
					shadow_words[shadow_wr] = r.word;
					shadow_wr++;
					// When overwriting, the oldest word is lost and the read side moves on.
					if (shadow_full) begin
						shadow_rd++;
					end else begin
						shadow_count++;
						if (shadow_count >= FIFO_DEPTH)
							shadow_full = 1'b1;
					end
					await_answer(rfdo_pkg::ST_OK, '0, 1'b1);
				end
			end
			rfdo_pkg::OP_GET: begin
				if (fifo_is_empty()) begin
					await_answer(rfdo_pkg::ST_NONE, '0, 1'b1);
				end else begin
					word = shadow_words[shadow_rd];
					shadow_rd++;
					if (shadow_count > 0)
						shadow_count--;
					shadow_full = 1'b0;
					await_answer(rfdo_pkg::ST_OK, word, 1'b1);
				end
			end
			rfdo_pkg::OP_PEEK: begin
				if (fifo_is_empty() || r.peek_max == '0) begin
					await_answer(rfdo_pkg::ST_NONE, '0, 1'b1);
				end else begin
					// A request for more entries than are held shows only those held.
					shown = 32'((r.peek_max < shadow_count) ? r.peek_max : shadow_count);
					pos = shadow_rd;
					for (int unsigned i = 0; i < shown; i++) begin
						await_answer(rfdo_pkg::ST_OK, shadow_words[pos], i + 1 == shown);
						pos++;
					end
				end
			end
			default: begin
				shadow_wr    = '0;
				shadow_rd    = '0;
				shadow_count = '0;
				shadow_full  = 1'b0;
				await_answer(rfdo_pkg::ST_OK, '0, 1'b1);
			end
		endcase
	endtask

	// The driver offers the next pending request when the slot is free: either
	// nothing is offered or the current request was accepted at the last rising
	// edge. A request that is offered stays put until it is accepted. The
	// receiver side stalls at random in the same block.
	always @(negedge clk) begin : drive_requests
		fifo_req_t next_req;
		if (!s_tvalid || req_taken) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_req = pending_reqs.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= next_req.op;
				s_tdata  <= {3'b000, next_req.peek_max, next_req.word};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		req_taken = 1'b0;
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// The monitor predicts on every accepted request and checks every accepted
	// result. A result leaves the output register only after its request is accepted, so
	// the order of the two parts within one edge does not matter.
	always @(posedge clk) begin : watch_streams
		fifo_req_t    seen_req;
		fifo_answer_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				seen_req.op       = rfdo_pkg::op_t'(s_tuser);
				seen_req.word     = s_tdata[rfdo_pkg::WORD_W-1:0];
				seen_req.peek_max = s_tdata[rfdo_pkg::WORD_W+rfdo_pkg::CNT_W-1:rfdo_pkg::WORD_W];
				predict_fifo_answers(seen_req);
				req_taken = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				if (awaited_answers.size() == 0) begin
					report_mismatch("unexpected result", m_tdata[rfdo_pkg::WORD_W-1:0], '0);
				end else begin
					want = awaited_answers.pop_front();
					if (m_tuser !== want.status)
						report_mismatch("status", rfdo_pkg::WORD_W'(m_tuser),
							rfdo_pkg::WORD_W'(want.status));
					if (m_tdata[rfdo_pkg::WORD_W-1:0] !== want.word)
						report_mismatch("data_out", m_tdata[rfdo_pkg::WORD_W-1:0], want.word);
					if (m_tlast !== want.last)
						report_mismatch("last", rfdo_pkg::WORD_W'(m_tlast),
							rfdo_pkg::WORD_W'(want.last));
					if (m_tdata[rfdo_pkg::WORD_W+rfdo_pkg::CNT_W-1:rfdo_pkg::WORD_W] !== want.fill)
						report_mismatch("fill_count", rfdo_pkg::WORD_W'(
							m_tdata[rfdo_pkg::WORD_W+rfdo_pkg::CNT_W-1:rfdo_pkg::WORD_W]),
							rfdo_pkg::WORD_W'(want.fill));
					if (m_tdata[rfdo_pkg::WORD_W+rfdo_pkg::CNT_W] !== want.full)
						report_mismatch("full_flag",
							rfdo_pkg::WORD_W'(m_tdata[rfdo_pkg::WORD_W+rfdo_pkg::CNT_W]),
							rfdo_pkg::WORD_W'(want.full));
					if (m_tdata[rfdo_pkg::WORD_W+rfdo_pkg::CNT_W+1] !== want.empty)
						report_mismatch("empty_flag",
							rfdo_pkg::WORD_W'(m_tdata[rfdo_pkg::WORD_W+rfdo_pkg::CNT_W+1]),
							rfdo_pkg::WORD_W'(want.empty));
				end
			end
		end
	end

	task automatic queue_req(input rfdo_pkg::op_t op,
			input logic [rfdo_pkg::WORD_W-1:0] word,
			input logic [rfdo_pkg::CNT_W-1:0] peek_max);
		fifo_req_t r;
		r.op       = op;
		r.word     = word;
		r.peek_max = peek_max;
		pending_reqs.push_back(r);
	endtask

	// Waits until every request has gone in and every result has come out.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (!(pending_reqs.size() == 0 && !s_tvalid && awaited_answers.size() == 0));
	endtask

	// Writes the policy register while the block is idle. The shadow copy takes
	// the new value at once, since no request can be accepted in between.
	task automatic set_overwrite(input logic value);
		@(negedge clk);
		cfg_wr_en        <= 1'b1;
		cfg_wr_data      <= value;
		shadow_overwrite  = value;
		@(negedge clk);
		cfg_wr_en        <= 1'b0;
	endtask

	// Mostly random words, with the all-zero and all-one patterns now and then.
	function automatic logic [rfdo_pkg::WORD_W-1:0] draw_word();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 5)
			return '0;
		else if (roll < 10)
			return '1;
		return $urandom;
	endfunction

	// Peek sizes: mostly within the depth, sometimes zero, sometimes beyond it.
	function automatic logic [rfdo_pkg::CNT_W-1:0] draw_peek_max();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 10)
			return '0;
		else if (roll < 20)
			return rfdo_pkg::CNT_W'($urandom_range(31, FIFO_DEPTH + 1));
		return rfdo_pkg::CNT_W'($urandom_range(FIFO_DEPTH, 1));
	endfunction

	// Chooses an operation with weights that depend on the tilt of the burst:
	// filling, draining or balanced. A clear is rare in every case so that the
	// FIFO gets the chance to fill and wrap.
	function automatic rfdo_pkg::op_t draw_op(input int unsigned tilt);
		int unsigned roll;
		int unsigned put_w;
		int unsigned get_w;
		roll = $urandom_range(99);
		case (tilt)
			0:       begin put_w = 70; get_w = 10; end
			1:       begin put_w = 20; get_w = 60; end
			default: begin put_w = 40; get_w = 35; end
		endcase
		if (roll < put_w)
			return rfdo_pkg::OP_PUT;
		else if (roll < put_w + get_w)
			return rfdo_pkg::OP_GET;
		else if (roll < 98)
			return rfdo_pkg::OP_PEEK;
		return rfdo_pkg::OP_CLEAR;
	endfunction

	// Random requests in bursts. A quarter of the bursts are long runs of puts,
	// which fill the FIFO and drive it into the refused or overwriting put.
	task automatic queue_random(input int unsigned total);
		int unsigned   made;
		int unsigned   run;
		int unsigned   tilt;
		rfdo_pkg::op_t op;
		made = 0;
		while (made < total) begin
			if ($urandom_range(3) == 0) begin
				run = $urandom_range(FIFO_DEPTH + 4, FIFO_DEPTH);
				for (int unsigned i = 0; i < run; i++)
					queue_req(rfdo_pkg::OP_PUT, draw_word(), draw_peek_max());
			end else begin
				run  = $urandom_range(12, 4);
				tilt = $urandom_range(2);
				for (int unsigned i = 0; i < run; i++) begin
					op = draw_op(tilt);
					queue_req(op, draw_word(), draw_peek_max());
				end
			end
			made += run;
		end
	endtask

	initial begin : sequence_run
		logic overwrite;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part with the dropping policy: reads of an empty FIFO, the
		// extreme words, a zero and an oversized peek, a clear, then a fill to
		// full followed by a put that must be refused.
		set_overwrite(1'b0);
		queue_req(rfdo_pkg::OP_GET,   '0, '0);
		queue_req(rfdo_pkg::OP_PEEK,  '0, 5'd5);
		queue_req(rfdo_pkg::OP_PUT,   '0, '0);
		queue_req(rfdo_pkg::OP_PUT,   '1, '1);
		queue_req(rfdo_pkg::OP_PEEK,  '0, '0);
		queue_req(rfdo_pkg::OP_PEEK,  '0, '1);
		queue_req(rfdo_pkg::OP_GET,   '0, '0);
		queue_req(rfdo_pkg::OP_CLEAR, '1, '1);
		queue_req(rfdo_pkg::OP_GET,   '0, '0);
		for (int unsigned i = 0; i < FIFO_DEPTH; i++)
			queue_req(rfdo_pkg::OP_PUT, 32'hC0DE_0000 | i, '0);
		queue_req(rfdo_pkg::OP_PUT,  32'hDEAD_BEEF, '0);
		queue_req(rfdo_pkg::OP_PEEK, '0, 5'd16);
		wait_drained();

		// Still full: with the overwriting policy the oldest words are replaced
		// and both pointers move on together, so the peek walks past the end and wraps.
		set_overwrite(1'b1);
		queue_req(rfdo_pkg::OP_PUT,  32'h3F80_0000, '0);
		queue_req(rfdo_pkg::OP_PUT,  32'hFF80_0000, '0);
		queue_req(rfdo_pkg::OP_PUT,  32'h7FC0_0001, '0);
		queue_req(rfdo_pkg::OP_PEEK, '0, '1);
		queue_req(rfdo_pkg::OP_GET,  '0, '0);
		wait_drained();

		// Random part: every combination of idling and policy, each phase
		// starting from whatever state the previous one left behind.
		for (int unsigned ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1:       begin send_idle_pct = 66; recv_stall_pct = 0;  end
				2:       begin send_idle_pct = 0;  recv_stall_pct = 66; end
				default: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
			endcase
			overwrite = (ph < 4) ? ph[0] : !ph[0];
			set_overwrite(overwrite);
			queue_random(30);
			wait_drained();
		end

		// A short tail catches any result the block sends beyond those awaited.
		repeat (20) @(negedge clk);
		if (awaited_answers.size() != 0)
			report_mismatch("missing results", awaited_answers.size(), '0);
		if (mismatch_count == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

	// Guards against a hang. The slowest correct run is far shorter than this.
	initial begin : watchdog
		#5_000_000;
		$display("tb: FAIL");
		$finish;
	end

endmodule

[sim.f]
src/rfdo_pkg.sv
src/rfdo_ctrl.sv
src/rfdo_dp.sv
src/ring_fifo_drop_or_overwrite.sv
bench/tb.sv
